// File: sv/assert_macros.svh
// Assertion macros shared by the pose integrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define SDPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define SDPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sdpi_pkg.sv
// Types and constants of the stick-driven pose integrator.
package sdpi_pkg;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_STEP = 3'b100
  } state_t;

  // Multiply steps of a time tick, in the order the sequencer runs them.
  typedef enum logic [6:0] {
    STEP_P1 = 7'b0000001,  // |speed| * rate
    STEP_P2 = 7'b0000010,  // * elapsed
    STEP_Z2 = 7'b0000100,  // z * z
    STEP_T  = 7'b0001000,  // 2320 * z2
    STEP_U  = 7'b0010000,  // z2 * (21024 - t)
    STEP_S  = 7'b0100000,  // z * (51472 - u)
    STEP_D  = 7'b1000000   // |dist| * |trig|
  } step_t;

  localparam logic [1:0] OP_STICK = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_TURN = 2'd2;

  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_MAX_VEL   = 2'd1;
  localparam logic [1:0] REG_MAX_TURN  = 2'd2;

  localparam logic [14:0] DEAD_ZONE_RST = 15'd3277;
  localparam logic [15:0] MAX_VEL_RST   = 16'd30000;
  localparam logic [15:0] MAX_TURN_RST  = 16'd36409;

  // Quarter-wave polynomial coefficients, Q14.
  localparam logic [15:0] POLY_A  = 16'd51472;
  localparam logic [14:0] POLY_B  = 15'd21024;
  localparam logic [11:0] POLY_C  = 12'd2320;
  localparam logic [14:0] QUARTER = 15'd16384;
  localparam logic [14:0] TRIG_MAX = 15'h7FFF;

  // Shift-add multiplier: radix-4 digits, two multiplier bits a cycle.
  localparam int MCAND_W  = 31;
  localparam int MPLIER_W = 16;
  localparam int ACC_W    = MCAND_W + MPLIER_W;
  localparam int DIGITS   = MPLIER_W / 2;

endpackage

// File: sv/stick_driven_pose_integrator.sv
// Stick-driven pose integrator: dead-zone mode select and dead-reckoning pose update.
// Stick, place and stopped-tick words: result valid in the cycle after acceptance.
// Turning tick: 2 multiplies, speed and time, then the heading update.
// Forward tick: 12 multiplies (speed, time, cos and sin polynomials, x and y step).
// Every multiply runs on one shared radix-4 shift-add unit, its digits in S_MUL, then S_STEP.
// Next word accepted once the result is taken; rst_n (sync, low) zeroes the pose, mode stopped.
`include "assert_macros.svh"

module stick_driven_pose_integrator
  import sdpi_pkg::*;
#(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // stick_x[15:0], stick_y[31:16], elapsed[47:32], place_x[79:48],
  // place_y[111:80], place_heading[127:112]
  input  logic [127:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], motion_mode[81:80],
  // place_refused[82], zero[87:83]
  output logic [87:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  // Phase of a table entry: heading with the bits below the table index cleared.
  localparam logic [15:0] PHASE_MASK = 16'hFFFF << (16 - SINE_BITS);

  function automatic logic signed [15:0] sat_speed(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sd32767;
    end else if (v < -17'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Configuration
  logic [14:0] dead_zone_r;
  logic [15:0] max_vel_r;
  logic [15:0] max_turn_r;

  // Pose and control
  state_t             state_r, state_nxt;
  step_t              step_r, step_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic signed [15:0] speed_r, speed_nxt;
  logic [31:0]        pos_x_r, pos_x_nxt;
  logic [31:0]        pos_y_r, pos_y_nxt;
  logic [15:0]        heading_r, heading_nxt;
  logic               refused_r, refused_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         cnt_r, cnt_nxt;

  // Datapath
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    mcand_r, mcand_nxt;
  logic [MPLIER_W-1:0] mplier_r, mplier_nxt;
  logic [15:0]         dt_r, dt_nxt;
  logic signed [16:0]  dist_r, dist_nxt;
  logic [14:0]         z_r, z_nxt;
  logic [1:0]          q_r, q_nxt;
  logic [14:0]         z2_r, z2_nxt;
  logic                trig_neg_r, trig_neg_nxt;
  logic                axis_r, axis_nxt;

  logic                in_fire;
  logic [1:0]          op;
  logic signed [16:0]  sx_ext, sy_ext, ax, ay, fwd_v;
  logic [15:0]         spd_neg;
  logic [14:0]         spd_mag;
  logic [16:0]         dist_neg, dist_mag;
  logic                prod_neg;
  logic [ACC_W:0]      acc_ext, sprod;
  logic [ACC_W-1:0]    pp;
  logic [15:0]         cos_phase, sin_phase, next_phase;
  logic [14:0]         z_raw, z_fold;
  logic [11:0]         t_val;
  logic [14:0]         u_val, s1_val;
  logic [15:0]         s2_val, s_val;
  logic [14:0]         trig;
  logic                load_en;
  logic [MCAND_W-1:0]  load_a;
  logic [MPLIER_W-1:0] load_b;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign op        = in_tuser;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, refused_r, mode_r, heading_r, pos_y_r, pos_x_r};

  // Stick decode
  assign sx_ext = {in_tdata[15], in_tdata[15:0]};
  assign sy_ext = {in_tdata[31], in_tdata[31:16]};
  assign ax     = sx_ext[16] ? -sx_ext : sx_ext;
  assign ay     = sy_ext[16] ? -sy_ext : sy_ext;
  assign fwd_v  = -sy_ext;

  assign spd_neg  = 16'(-speed_r);
  assign spd_mag  = speed_r[15] ? spd_neg[14:0] : speed_r[14:0];
  assign dist_neg = 17'(-dist_r);
  assign dist_mag = dist_r[16] ? dist_neg : dist_r;

  // Signed product, floored by taking the upper bits
  assign prod_neg = (step_r == STEP_P2) ? speed_r[15] : (dist_r[16] ^ trig_neg_r);
  assign acc_ext  = {1'b0, acc_r};
  assign sprod    = prod_neg ? -acc_ext : acc_ext;

  // One radix-4 digit of the shift-add multiplier
  assign pp = (mplier_r[0] ? mcand_r : '0) +
              (mplier_r[1] ? {mcand_r[ACC_W-2:0], 1'b0} : '0);

  // Cos phase sits a quarter turn ahead of the sin phase
  assign sin_phase  = heading_r & PHASE_MASK;
  assign cos_phase  = sin_phase + 16'h4000;
  assign next_phase = (step_r == STEP_P2) ? cos_phase : sin_phase;
  assign z_raw      = {1'b0, next_phase[13:0]};
  assign z_fold     = next_phase[14] ? (QUARTER - z_raw) : z_raw;

  // Polynomial terms from the finished product
  assign t_val  = acc_r[25:14];
  assign s1_val = POLY_B - {3'b0, t_val};
  assign u_val  = acc_r[28:14];
  assign s2_val = POLY_A - {1'b0, u_val};
  assign s_val  = acc_r[29:14];
  assign trig   = (s_val > {1'b0, TRIG_MAX}) ? TRIG_MAX : s_val[14:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    speed_nxt     = speed_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    refused_nxt   = refused_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    dt_nxt        = dt_r;
    dist_nxt      = dist_r;
    z_nxt         = z_r;
    q_nxt         = q_r;
    z2_nxt        = z2_r;
    trig_neg_nxt  = trig_neg_r;
    axis_nxt      = axis_r;
    load_en       = 1'b0;
    load_a        = '0;
    load_b        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          refused_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          case (op)
            OP_STICK: begin
              if (ay > {2'b0, dead_zone_r}) begin
                mode_nxt  = MODE_FWD;
                speed_nxt = sat_speed(fwd_v);
              end else if (ax > {2'b0, dead_zone_r}) begin
                mode_nxt  = MODE_TURN;
                speed_nxt = sat_speed(sx_ext);
              end else begin
                mode_nxt = MODE_STOP;
              end
            end
            OP_TICK: begin
              dt_nxt = in_tdata[47:32];
              if (mode_r == MODE_FWD || mode_r == MODE_TURN) begin
                // hold the result back until the integration is done
                out_valid_nxt = 1'b0;
                load_en       = 1'b1;
                load_a        = {16'b0, spd_mag};
                load_b        = (mode_r == MODE_FWD) ? max_vel_r : max_turn_r;
                step_nxt      = STEP_P1;
              end
            end
            OP_PLACE: begin
              if (mode_r != MODE_STOP) begin
                refused_nxt = 1'b1;
              end else begin
                pos_x_nxt   = in_tdata[79:48];
                pos_y_nxt   = in_tdata[111:80];
                heading_nxt = in_tdata[127:112];
              end
            end
            default: ;
          endcase
        end
      end

      S_MUL: begin
        acc_nxt    = acc_r + pp;
        mcand_nxt  = {mcand_r[ACC_W-3:0], 2'b00};
        mplier_nxt = {2'b00, mplier_r[MPLIER_W-1:2]};
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'(DIGITS - 1)) begin
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        unique case (step_r)
          STEP_P1: begin
            load_en  = 1'b1;
            load_a   = acc_r[MCAND_W-1:0];
            load_b   = dt_r;
            step_nxt = STEP_P2;
          end
          STEP_P2: begin
            if (mode_r == MODE_TURN) begin
              heading_nxt   = heading_r - sprod[46:31];
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
            end else begin
              dist_nxt = sprod[47:31];
              axis_nxt = 1'b0;
              z_nxt    = z_fold;
              q_nxt    = next_phase[15:14];
              load_en  = 1'b1;
              load_a   = {16'b0, z_fold};
              load_b   = {1'b0, z_fold};
              step_nxt = STEP_Z2;
            end
          end
          STEP_Z2: begin
            z2_nxt   = acc_r[28:14];
            load_en  = 1'b1;
            load_a   = {19'b0, POLY_C};
            load_b   = {1'b0, acc_r[28:14]};
            step_nxt = STEP_T;
          end
          STEP_T: begin
            load_en  = 1'b1;
            load_a   = {16'b0, z2_r};
            load_b   = {1'b0, s1_val};
            step_nxt = STEP_U;
          end
          STEP_U: begin
            load_en  = 1'b1;
            load_a   = {16'b0, z_r};
            load_b   = s2_val;
            step_nxt = STEP_S;
          end
          STEP_S: begin
            trig_neg_nxt = q_r[1];
            load_en      = 1'b1;
            load_a       = {14'b0, dist_mag};
            load_b       = {1'b0, trig};
            step_nxt     = STEP_D;
          end
          STEP_D: begin
            if (!axis_r) begin
              pos_x_nxt = pos_x_r + sprod[46:15];
              // advance to the sine half of the step
              axis_nxt  = 1'b1;
              z_nxt     = z_fold;
              q_nxt     = next_phase[15:14];
              load_en   = 1'b1;
              load_a    = {16'b0, z_fold};
              load_b    = {1'b0, z_fold};
              step_nxt  = STEP_Z2;
            end else begin
              pos_y_nxt     = pos_y_r + sprod[46:15];
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_en) begin
      state_nxt  = S_MUL;
      acc_nxt    = '0;
      mcand_nxt  = {{MPLIER_W{1'b0}}, load_a};
      mplier_nxt = load_b;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DEAD_ZONE_RST;
      max_vel_r   <= MAX_VEL_RST;
      max_turn_r  <= MAX_TURN_RST;
      state_r     <= S_IDLE;
      step_r      <= STEP_P1;
      mode_r      <= MODE_STOP;
      speed_r     <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      refused_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEAD_ZONE: dead_zone_r <= cfg_data[14:0];
          REG_MAX_VEL:   max_vel_r   <= cfg_data;
          REG_MAX_TURN:  max_turn_r  <= cfg_data;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mode_r      <= mode_nxt;
      speed_r     <= speed_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      refused_r   <= refused_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    dt_r       <= dt_nxt;
    dist_r     <= dist_nxt;
    z_r        <= z_nxt;
    q_r        <= q_nxt;
    z2_r       <= z2_nxt;
    trig_neg_r <= trig_neg_nxt;
    axis_r     <= axis_nxt;
  end

  `SDPI_ASSERT_NOW(a_no_result_while_busy, state_r != S_IDLE, !out_valid_r, "result word shown mid-integration")
  `SDPI_ASSERT_NEXT(a_place_refused, in_fire && op == OP_PLACE && mode_r != MODE_STOP, out_valid_r && refused_r, "place while moving not refused")
  `SDPI_ASSERT_NEXT(a_mode_on_stick_only, !(in_fire && op == OP_STICK), $stable(mode_r), "mode changed without a stick word")

endmodule
